@@ hdl/c8vm_pkg.sv @@
// Shared types and constants for the bytecode VM execute unit.
// No dependencies; imported by c8vm_alu and bytecode_vm_execute_unit_top.
package c8vm_pkg;

  localparam int MEM_DEPTH       = 4096;
  localparam int MEM_AW          = $clog2(MEM_DEPTH);
  localparam int STACK_DEPTH     = 16;
  localparam int SP_W            = $clog2(STACK_DEPTH);
  localparam int SCREEN_W        = 64;
  localparam int SCREEN_H        = 32;
  localparam int ROW_W           = $clog2(SCREEN_H);
  localparam int COL_W           = $clog2(SCREEN_W);
  localparam int MAX_SPRITE_ROWS = 15;

  localparam logic [11:0] FONT_BASE_RST  = 12'd80;
  localparam logic [11:0] PROG_START_RST = 12'd512;

  typedef enum logic [2:0] {
    MODE_WR_MEM  = 3'd0,
    MODE_EXEC    = 3'd1,
    MODE_RD_ROW  = 3'd2,
    MODE_RD_REG  = 3'd3,
    MODE_RD_MEM  = 3'd4
  } mode_t;

  localparam logic [1:0] TW_NONE  = 2'd0;
  localparam logic [1:0] TW_DELAY = 2'd1;
  localparam logic [1:0] TW_SOUND = 2'd2;

  localparam logic CFG_FONT_BASE  = 1'b0;
  localparam logic CFG_PROG_START = 1'b1;

  // 8XYn sub-operations
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  typedef struct packed {
    logic       x_we;
    logic [7:0] x_val;
    logic       f_we;
    logic [7:0] f_val;
  } alu_res_t;

endpackage

@@ hdl/bytecode_vm_execute_unit_top.sv @@
// Top level of the bytecode VM execute unit: sequencer, byte memory, registers, screen.
// Depends on c8vm_pkg and c8vm_alu.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in_     | input     | in_valid / in_stall  | mode, opcode, address, write_data, keys..
//  out_    | output    | out_valid / out_stall| pc, index, flag, draw, timer, wait, data
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index (0 font_base, 1 program_start)
//
// An item passes through accept, execute and result load; mode 4 adds a state for the RAM read.
// DXYN and FX65 read then write per sprite row or byte; FX55 and FX33 only write bytes:
// the single-port byte RAM with its registered read sets these steps.
// Reset is synchronous: registers, I, SP and the whole screen clear, PC loads 512.
// The result sits in an output register; a new item is taken while it waits, and the
// sequencer holds the next result until out_stall drops.
module bytecode_vm_execute_unit_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_mode,
  input  logic [15:0]           in_opcode,
  input  logic [11:0]           in_address,
  input  logic [7:0]            in_write_data,
  input  logic [15:0]           in_key_mask,
  input  logic [15:0]           in_prev_key_mask,
  input  logic [7:0]            in_delay_value,
  input  logic [7:0]            in_random_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [11:0]           out_pc_value,
  output logic [15:0]           out_index_value,
  output logic [7:0]            out_flag_value,
  output logic                  out_draw_flag,
  output logic [1:0]            out_timer_write,
  output logic [7:0]            out_timer_value,
  output logic                  out_waiting,
  output logic [63:0]           out_read_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [11:0]           cfg_write_data
);
  import c8vm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_MRD, ST_DRAW_RD, ST_DRAW_WR,
    ST_LD_RD, ST_LD_WR, ST_STO, ST_BCD, ST_FIN
  } st_t;

  st_t                  st_r;

  // captured item
  logic [2:0]           mode_r;
  logic [15:0]          op_r;
  logic [11:0]          addr_r;
  logic [7:0]           wdata_r;
  logic [15:0]          keys_r;
  logic [15:0]          prev_r;
  logic [7:0]           delay_r;
  logic [7:0]           rnd_r;

  // architectural state
  logic [7:0]           v_r [16];
  logic [15:0]          i_r;
  logic [11:0]          pc_r;
  logic [11:0]          stack_r [STACK_DEPTH];
  logic [SP_W-1:0]      sp_r;
  logic [SCREEN_W-1:0]  screen_r [SCREEN_H];
  logic [11:0]          font_base_r;

  // per-item scratch
  logic [3:0]           cnt_r;
  logic [3:0]           nrows_r;
  logic [COL_W-1:0]     col0_r;
  logic [ROW_W-1:0]     row0_r;
  logic                 hit_r;
  logic                 draw_r;
  logic [1:0]           tw_r;
  logic [7:0]           tv_r;
  logic                 wait_r;
  logic [63:0]          rdata_r;

  // output register
  logic                 out_valid_r;
  logic [11:0]          out_pc_r;
  logic [15:0]          out_idx_r;
  logic [7:0]           out_flag_r;
  logic                 out_draw_r;
  logic [1:0]           out_tw_r;
  logic [7:0]           out_tv_r;
  logic                 out_wait_r;
  logic [63:0]          out_rdata_r;

  // byte RAM
  logic [7:0]           mem [MEM_DEPTH];
  logic [7:0]           mem_q;
  logic                 mem_we;
  logic                 mem_re;
  logic [MEM_AW-1:0]    mem_addr;
  logic [7:0]           mem_wd;

  // decode
  logic [3:0]           x;
  logic [3:0]           y;
  logic [3:0]           n;
  logic [7:0]           nn;
  logic [11:0]          nnn;
  logic [7:0]           vx;
  logic [7:0]           vy;
  logic [11:0]          pc_inc;
  logic [11:0]          pc_skip;
  logic [SP_W-1:0]      sp_inc;
  logic [SP_W-1:0]      sp_dec;
  logic [MEM_AW-1:0]    i_off;
  logic [6:0]           row_sum;
  logic [ROW_W-1:0]     row_idx;
  logic [SCREEN_W-1:0]  spr_mask;
  logic [SCREEN_W-1:0]  cur_line;
  logic [15:0]          i_adv;
  logic [1:0]           bcd_h;
  logic [7:0]           bcd_rem;
  logic [15:0]          bcd_prod;
  logic [3:0]           bcd_t;
  logic [7:0]           bcd_o;
  logic [7:0]           bcd_digit;
  logic [3:0]           key_idx;
  alu_res_t             alu_res;
  logic                 out_free;

  assign in_stall  = (st_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign x       = op_r[11:8];
  assign y       = op_r[7:4];
  assign n       = op_r[3:0];
  assign nn      = op_r[7:0];
  assign nnn     = op_r[11:0];
  assign vx      = v_r[x];
  assign vy      = v_r[y];
  assign pc_inc  = pc_r + 12'd2;
  assign pc_skip = pc_r + 12'd4;
  assign sp_inc  = (sp_r == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
  assign sp_dec  = (sp_r == '0) ? SP_W'(STACK_DEPTH - 1) : sp_r - 1'b1;
  assign i_off   = i_r[MEM_AW-1:0] + MEM_AW'(cnt_r);
  assign i_adv   = i_r + 16'(x) + 16'd1;

  assign row_sum  = 7'(row0_r) + 7'(cnt_r);
  assign row_idx  = row_sum[ROW_W-1:0];
  assign cur_line = screen_r[row_idx];
  assign spr_mask = {mem_q, {(SCREEN_W-8){1'b0}}} >> col0_r;

  // decimal digits of vx
  assign bcd_h     = (vx >= 8'd200) ? 2'd2 : ((vx >= 8'd100) ? 2'd1 : 2'd0);
  assign bcd_rem   = vx - 8'(bcd_h) * 8'd100;
  assign bcd_prod  = 16'(bcd_rem) * 16'd205;   // x*205 >> 11 == x/10 for x < 1024
  assign bcd_t     = bcd_prod[14:11];
  assign bcd_o     = bcd_rem - 8'(bcd_t) * 8'd10;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    bcd_digit = 8'(bcd_h);
      2'd1:    bcd_digit = 8'(bcd_t);
      default: bcd_digit = bcd_o;
    endcase
  end

  // lowest bit where the key masks differ
  always_comb begin
    key_idx = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k] ^ prev_r[k]) key_idx = 4'(k);
    end
  end

  c8vm_alu u_alu (
    .vx     (vx),
    .vy     (vy),
    .sub_op (n),
    .res    (alu_res)
  );

  // RAM port control
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = i_off;
    mem_wd   = v_r[cnt_r];
    unique case (st_r)
      ST_EXEC: begin
        mem_addr = MEM_AW'(addr_r);
        mem_wd   = wdata_r;
        mem_we   = (mode_r == MODE_WR_MEM) && (32'(addr_r) < MEM_DEPTH);
        mem_re   = (mode_r == MODE_RD_MEM);
      end
      ST_DRAW_RD: mem_re = (cnt_r < nrows_r) && (32'(row_sum) < SCREEN_H);
      ST_LD_RD:   mem_re = 1'b1;
      ST_STO:     mem_we = 1'b1;
      ST_BCD: begin
        mem_we = 1'b1;
        mem_wd = bcd_digit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      pc_r        <= PROG_START_RST;
      sp_r        <= '0;
      font_base_r <= FONT_BASE_RST;
      for (int k = 0; k < 16; k++) v_r[k] <= '0;
      for (int k = 0; k < SCREEN_H; k++) screen_r[k] <= '0;
    end else begin
      // program_start only matters at reset, which reloads its reset value
      if (cfg_valid && cfg_index == CFG_FONT_BASE) font_base_r <= cfg_write_data;

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (st_r)
        ST_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            op_r    <= in_opcode;
            addr_r  <= in_address;
            wdata_r <= in_write_data;
            keys_r  <= in_key_mask;
            prev_r  <= in_prev_key_mask;
            delay_r <= in_delay_value;
            rnd_r   <= in_random_byte;
            draw_r  <= 1'b0;
            tw_r    <= TW_NONE;
            tv_r    <= '0;
            wait_r  <= 1'b0;
            rdata_r <= '0;
            cnt_r   <= '0;
            hit_r   <= 1'b0;
            st_r    <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          st_r <= ST_FIN;
          case (mode_r)
            MODE_RD_ROW: begin
              if (32'(addr_r) < SCREEN_H) rdata_r <= 64'(screen_r[ROW_W'(addr_r)]);
            end
            MODE_RD_REG: begin
              if (addr_r < 12'd16) rdata_r <= 64'(v_r[addr_r[3:0]]);
            end
            MODE_RD_MEM: st_r <= ST_MRD;
            MODE_EXEC: begin
              pc_r <= pc_inc;
              case (op_r[15:12])
                4'h0: begin
                  if (op_r == 16'h00E0) begin
                    for (int k = 0; k < SCREEN_H; k++) screen_r[k] <= '0;
                    draw_r <= 1'b1;
                  end else if (op_r == 16'h00EE) begin
                    sp_r <= sp_dec;
                    pc_r <= stack_r[sp_dec];
                  end
                end
                4'h1: pc_r <= nnn;
                4'h2: begin
                  stack_r[sp_r] <= pc_inc;
                  sp_r          <= sp_inc;
                  pc_r          <= nnn;
                end
                4'h3: if (vx == nn) pc_r <= pc_skip;
                4'h4: if (vx != nn) pc_r <= pc_skip;
                4'h5: if (n == 4'd0 && vx == vy) pc_r <= pc_skip;
                4'h6: v_r[x] <= nn;
                4'h7: v_r[x] <= vx + nn;
                4'h8: begin
                  if (alu_res.x_we) v_r[x] <= alu_res.x_val;
                  if (alu_res.f_we) v_r[15] <= alu_res.f_val;  // flag wins over VF dest
                end
                4'h9: if (n == 4'd0 && vx != vy) pc_r <= pc_skip;
                4'hA: i_r <= 16'(nnn);
                4'hB: pc_r <= 12'(v_r[0]) + nnn;
                4'hC: v_r[x] <= rnd_r & nn;
                4'hD: begin
                  draw_r  <= 1'b1;
                  col0_r  <= COL_W'(vx % SCREEN_W);
                  row0_r  <= ROW_W'(vy % SCREEN_H);
                  nrows_r <= (n > 4'(MAX_SPRITE_ROWS)) ? 4'(MAX_SPRITE_ROWS) : n;
                  st_r    <= ST_DRAW_RD;
                end
                4'hE: begin
                  if (nn == 8'h9E && keys_r[vx[3:0]]) pc_r <= pc_skip;
                  else if (nn == 8'hA1 && !keys_r[vx[3:0]]) pc_r <= pc_skip;
                end
                default: begin
                  case (nn)
                    8'h07: v_r[x] <= delay_r;
                    8'h0A: begin
                      if (prev_r <= keys_r) begin
                        pc_r   <= pc_r;   // back to this instruction
                        wait_r <= 1'b1;
                      end else begin
                        v_r[x] <= 8'(key_idx);
                      end
                    end
                    8'h15: begin tw_r <= TW_DELAY; tv_r <= vx; end
                    8'h18: begin tw_r <= TW_SOUND; tv_r <= vx; end
                    8'h1E: i_r <= i_r + 16'(vx);
                    8'h29: i_r <= 16'(font_base_r) + 16'(vx[3:0]) * 16'd5;
                    8'h33: st_r <= ST_BCD;
                    8'h55: st_r <= ST_STO;
                    8'h65: st_r <= ST_LD_RD;
                    default: ;
                  endcase
                end
              endcase
            end
            default: ;
          endcase
        end

        ST_MRD: begin
          rdata_r <= 64'(mem_q);
          st_r    <= ST_FIN;
        end

        ST_DRAW_RD: begin
          if (mem_re) begin
            st_r <= ST_DRAW_WR;
          end else begin
            v_r[15] <= {7'd0, hit_r};
            st_r    <= ST_FIN;
          end
        end

        ST_DRAW_WR: begin
          screen_r[row_idx] <= cur_line ^ spr_mask;
          if (|(cur_line & spr_mask)) hit_r <= 1'b1;
          cnt_r <= cnt_r + 4'd1;
          st_r  <= ST_DRAW_RD;
        end

        ST_LD_RD: st_r <= ST_LD_WR;

        ST_LD_WR: begin
          v_r[cnt_r] <= mem_q;
          if (cnt_r == x) begin
            i_r  <= i_adv;
            st_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + 4'd1;
            st_r  <= ST_LD_RD;
          end
        end

        ST_STO: begin
          if (cnt_r == x) begin
            i_r  <= i_adv;
            st_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end

        ST_BCD: begin
          if (cnt_r == 4'd2) st_r <= ST_FIN;
          else cnt_r <= cnt_r + 4'd1;
        end

        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pc_r    <= pc_r;
            out_idx_r   <= i_r;
            out_flag_r  <= v_r[15];
            out_draw_r  <= draw_r;
            out_tw_r    <= tw_r;
            out_tv_r    <= tv_r;
            out_wait_r  <= wait_r;
            out_rdata_r <= rdata_r;
            st_r        <= ST_IDLE;
          end
        end

        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pc_value    = out_pc_r;
  assign out_index_value = out_idx_r;
  assign out_flag_value  = out_flag_r;
  assign out_draw_flag   = out_draw_r;
  assign out_timer_write = out_tw_r;
  assign out_timer_value = out_tv_r;
  assign out_waiting     = out_wait_r;
  assign out_read_data   = out_rdata_r;

`ifndef SYNTHESIS
  a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("RAM read and write in the same cycle");

  a_draw_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DRAW_WR) |-> (32'(row_sum) < SCREEN_H))
    else $error("sprite row beyond screen bottom");

  a_block_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_STO || st_r == ST_LD_RD || st_r == ST_LD_WR) |-> (cnt_r <= x))
    else $error("register block transfer overran Vx");

  a_bcd_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BCD) |-> (cnt_r <= 4'd2))
    else $error("BCD store overran three digits");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN && out_free) |=> (out_valid_r && st_r == ST_IDLE))
    else $error("result not loaded into output register");
`endif

endmodule

@@ hdl/c8vm_alu.sv @@
// Register-to-register ALU for the 8XYn instruction group.
// Depends on c8vm_pkg (alu_res_t, ALU_* codes).
module c8vm_alu (
  input  logic [7:0]          vx,
  input  logic [7:0]          vy,
  input  logic [3:0]          sub_op,
  output c8vm_pkg::alu_res_t  res
);
  import c8vm_pkg::*;

  logic [8:0] sum;

  assign sum = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    res = '0;
    unique case (sub_op)
      ALU_MOV: begin
        res.x_we = 1'b1; res.x_val = vy;
      end
      ALU_OR: begin
        res.x_we = 1'b1; res.x_val = vx | vy; res.f_we = 1'b1;
      end
      ALU_AND: begin
        res.x_we = 1'b1; res.x_val = vx & vy; res.f_we = 1'b1;
      end
      ALU_XOR: begin
        res.x_we = 1'b1; res.x_val = vx ^ vy; res.f_we = 1'b1;
      end
      ALU_ADD: begin
        res.x_we = 1'b1; res.x_val = sum[7:0];
        res.f_we = 1'b1; res.f_val = {7'd0, sum[8]};
      end
      ALU_SUB: begin
        res.x_we = 1'b1; res.x_val = vx - vy;
        res.f_we = 1'b1; res.f_val = {7'd0, (vy <= vx)};
      end
      ALU_SHR: begin
        res.x_we = 1'b1; res.x_val = {1'b0, vy[7:1]};
        res.f_we = 1'b1; res.f_val = {7'd0, vy[0]};
      end
      ALU_SBN: begin
        res.x_we = 1'b1; res.x_val = vy - vx;
        res.f_we = 1'b1; res.f_val = {7'd0, (vx <= vy)};
      end
      ALU_SHL: begin
        res.x_we = 1'b1; res.x_val = {vy[6:0], 1'b0};
        res.f_we = 1'b1; res.f_val = {7'd0, vy[7]};
      end
      default: res = '0;
    endcase
  end

endmodule

@@ verif/tb_bytecode_vm_execute_unit_top.sv @@
// Self-checking testbench for bytecode_vm_execute_unit_top: directed table, then random items.
// Depends on c8vm_pkg and the RTL under hdl/; an internal predictor supplies expected results.
`timescale 1ns / 1ps

module tb_bytecode_vm_execute_unit_top;
  import c8vm_pkg::*;

  // major opcode nibble
  typedef enum logic [3:0] {
    OP_SYS = 4'h0, OP_JP = 4'h1, OP_CALL = 4'h2, OP_SE_IMM = 4'h3, OP_SNE_IMM = 4'h4,
    OP_SE_REG = 4'h5, OP_LD_IMM = 4'h6, OP_ADD_IMM = 4'h7, OP_ALU = 4'h8,
    OP_SNE_REG = 4'h9, OP_LD_I = 4'hA, OP_JP_V0 = 4'hB, OP_RND = 4'hC, OP_DRW = 4'hD,
    OP_KEY = 4'hE, OP_MISC = 4'hF
  } op_class_t;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;
  localparam logic [7:0] KEY_DOWN = 8'h9E;
  localparam logic [7:0] KEY_UP   = 8'hA1;
  localparam logic [7:0] FX_GET_DELAY = 8'h07;
  localparam logic [7:0] FX_WAIT_KEY  = 8'h0A;
  localparam logic [7:0] FX_SET_DELAY = 8'h15;
  localparam logic [7:0] FX_SET_SOUND = 8'h18;
  localparam logic [7:0] FX_ADD_I     = 8'h1E;
  localparam logic [7:0] FX_FONT      = 8'h29;
  localparam logic [7:0] FX_BCD       = 8'h33;
  localparam logic [7:0] FX_STORE     = 8'h55;
  localparam logic [7:0] FX_LOAD      = 8'h65;
  localparam int LIMIT_NS = 40_000_000;

  typedef struct {
    logic [2:0]  mode;
    logic [15:0] opcode;
    logic [11:0] addr;
    logic [7:0]  wdata;
    logic [15:0] keys;
    logic [15:0] prev;
    logic [7:0]  delay;
    logic [7:0]  rnd;
  } vm_item_t;

  typedef struct {
    logic [11:0] pc;
    logic [15:0] index;
    logic [7:0]  flag;
    logic        draw;
    logic [1:0]  twrite;
    logic [7:0]  tval;
    logic        waiting;
    logic [63:0] rdata;
  } vm_result_t;

  typedef struct {
    vm_item_t   it;
    bit         typed;  // expected result written in the table
    vm_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_mode = '0;
  logic [15:0] in_opcode = '0;
  logic [11:0] in_address = '0;
  logic [7:0] in_write_data = '0;
  logic [15:0] in_key_mask = '0;
  logic [15:0] in_prev_key_mask = '0;
  logic [7:0] in_delay_value = '0;
  logic [7:0] in_random_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] out_pc_value;
  logic [15:0] out_index_value;
  logic [7:0] out_flag_value;
  logic out_draw_flag;
  logic [1:0] out_timer_write;
  logic [7:0] out_timer_value;
  logic out_waiting;
  logic [63:0] out_read_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [11:0] cfg_write_data = '0;

  bytecode_vm_execute_unit_top DUT (.*);

  // Shadow copy of the machine state, advanced once per accepted item.
  logic [7:0]  mem_shadow [MEM_DEPTH];
  logic [7:0]  v_shadow [16];
  logic [15:0] i_shadow;
  logic [11:0] pc_shadow;
  logic [11:0] stack_shadow [STACK_DEPTH];
  bit          stack_written [STACK_DEPTH];
  logic [3:0]  sp_shadow;
  logic [63:0] screen_shadow [SCREEN_H];
  logic [11:0] font_base_q;

  vm_result_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Sprite XOR with clipping; returns 1 when a lit pixel was turned off.
  function automatic bit draw_sprite(logic [3:0] xr, logic [3:0] yr, int rows);
    int col0, row0;
    bit hit;
    logic [7:0] bits;
    int bi;
    col0 = v_shadow[xr] % SCREEN_W;
    row0 = v_shadow[yr] % SCREEN_H;
    hit = 0;
    if (rows > MAX_SPRITE_ROWS) rows = MAX_SPRITE_ROWS;
    for (int r = 0; r < rows && row0 + r < SCREEN_H; r++) begin
      bits = mem_shadow[(i_shadow + r) % MEM_DEPTH];
      for (int c = 0; c < 8 && col0 + c < SCREEN_W; c++) begin
        if (bits[7-c]) begin
          bi = SCREEN_W - 1 - (col0 + c);
          if (screen_shadow[row0 + r][bi]) hit = 1;
          screen_shadow[row0 + r][bi] = ~screen_shadow[row0 + r][bi];
        end
      end
    end
    return hit;
  endfunction

  function automatic vm_result_t vm_execute(vm_item_t it);
    vm_result_t res;
    logic [3:0] x, y, n;
    logic [7:0] nn, vx, vy;
    logic [11:0] nnn;
    logic [15:0] diff;
    int k;
    res = '{default: '0};
    x = it.opcode[11:8];
    y = it.opcode[7:4];
    n = it.opcode[3:0];
    nn = it.opcode[7:0];
    nnn = it.opcode[11:0];
    vx = v_shadow[x];
    vy = v_shadow[y];
    case (it.mode)
      MODE_WR_MEM: mem_shadow[it.addr] = it.wdata;
      MODE_RD_ROW: if (it.addr < SCREEN_H) res.rdata = screen_shadow[it.addr];
      MODE_RD_REG: if (it.addr < 16) res.rdata = 64'(v_shadow[it.addr]);
      MODE_RD_MEM: res.rdata = 64'(mem_shadow[it.addr]);
      MODE_EXEC: begin
        pc_shadow = pc_shadow + 12'd2;
        case (op_class_t'(it.opcode[15:12]))
          OP_SYS:
            if (it.opcode == OPC_CLS) begin
              foreach (screen_shadow[r]) screen_shadow[r] = '0;
              res.draw = 1;
            end else if (it.opcode == OPC_RET) begin
              sp_shadow = sp_shadow - 4'd1;
              pc_shadow = stack_shadow[sp_shadow];
            end
          OP_JP: pc_shadow = nnn;
          OP_CALL: begin
            stack_shadow[sp_shadow] = pc_shadow;
            stack_written[sp_shadow] = 1;
            sp_shadow = sp_shadow + 4'd1;
            pc_shadow = nnn;
          end
          OP_SE_IMM:  if (vx == nn) pc_shadow = pc_shadow + 12'd2;
          OP_SNE_IMM: if (vx != nn) pc_shadow = pc_shadow + 12'd2;
          OP_SE_REG:  if (n == 0 && vx == vy) pc_shadow = pc_shadow + 12'd2;
          OP_LD_IMM:  v_shadow[x] = nn;
          OP_ADD_IMM: v_shadow[x] = vx + nn;
          OP_ALU:
            case (n)
              ALU_MOV: v_shadow[x] = vy;
              ALU_OR:  begin v_shadow[x] = vx | vy; v_shadow[15] = 0; end
              ALU_AND: begin v_shadow[x] = vx & vy; v_shadow[15] = 0; end
              ALU_XOR: begin v_shadow[x] = vx ^ vy; v_shadow[15] = 0; end
              ALU_ADD: begin
                v_shadow[x] = vx + vy;
                v_shadow[15] = ({1'b0, vx} + {1'b0, vy}) > 9'hFF;
              end
              ALU_SUB: begin v_shadow[x] = vx - vy; v_shadow[15] = (vy <= vx); end
              ALU_SHR: begin v_shadow[x] = vy >> 1; v_shadow[15] = vy[0]; end
              ALU_SBN: begin v_shadow[x] = vy - vx; v_shadow[15] = (vx <= vy); end
              ALU_SHL: begin v_shadow[x] = vy << 1; v_shadow[15] = vy[7]; end
              default: ;
            endcase
          OP_SNE_REG: if (n == 0 && vx != vy) pc_shadow = pc_shadow + 12'd2;
          OP_LD_I:    i_shadow = 16'(nnn);
          OP_JP_V0:   pc_shadow = 12'(v_shadow[0]) + nnn;
          OP_RND:     v_shadow[x] = it.rnd & nn;
          OP_DRW: begin
            v_shadow[15] = 8'(draw_sprite(x, y, n));
            res.draw = 1;
          end
          OP_KEY:
            if (nn == KEY_DOWN && it.keys[vx[3:0]]) pc_shadow = pc_shadow + 12'd2;
            else if (nn == KEY_UP && !it.keys[vx[3:0]]) pc_shadow = pc_shadow + 12'd2;
          OP_MISC:
            case (nn)
              FX_GET_DELAY: v_shadow[x] = it.delay;
              FX_WAIT_KEY:
                if (it.prev <= it.keys) begin
                  pc_shadow = pc_shadow - 12'd2;
                  res.waiting = 1;
                end else begin
                  diff = it.keys ^ it.prev;
                  for (k = 0; k < 16; k++) if (diff[k]) break;
                  v_shadow[x] = 8'(k);
                end
              FX_SET_DELAY: begin res.twrite = TW_DELAY; res.tval = vx; end
              FX_SET_SOUND: begin res.twrite = TW_SOUND; res.tval = vx; end
              FX_ADD_I: i_shadow = i_shadow + 16'(vx);
              FX_FONT: i_shadow = 16'(font_base_q) + 16'(5 * vx[3:0]);
              FX_BCD: begin
                mem_shadow[i_shadow % MEM_DEPTH] = vx / 100;
                mem_shadow[(i_shadow + 1) % MEM_DEPTH] = (vx / 10) % 10;
                mem_shadow[(i_shadow + 2) % MEM_DEPTH] = vx % 10;
              end
              FX_STORE: begin
                for (k = 0; k <= x; k++) mem_shadow[(i_shadow + k) % MEM_DEPTH] = v_shadow[k];
                i_shadow = i_shadow + 16'(x) + 16'd1;
              end
              FX_LOAD: begin
                for (k = 0; k <= x; k++) v_shadow[k] = mem_shadow[(i_shadow + k) % MEM_DEPTH];
                i_shadow = i_shadow + 16'(x) + 16'd1;
              end
              default: ;
            endcase
          default: ;
        endcase
      end
      default: ;  // spare modes only report state
    endcase
    res.pc = pc_shadow;
    res.index = i_shadow;
    res.flag = v_shadow[15];
    return res;
  endfunction

  // Hand one item to the block, then queue what it should return.
  task automatic send_item(vm_item_t it, bit typed = 0, vm_result_t typed_res = '{default: '0});
    vm_result_t res;
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_opcode <= it.opcode;
    in_address <= it.addr;
    in_write_data <= it.wdata;
    in_key_mask <= it.keys;
    in_prev_key_mask <= it.prev;
    in_delay_value <= it.delay;
    in_random_byte <= it.rnd;
    do @(posedge clk); while (in_stall);
    res = vm_execute(it);
    expected_q.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  // Let everything in flight come out, plus slack for a still-busy sequencer.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_write_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FONT_BASE) font_base_q = val;
  endtask

  function automatic vm_item_t rand_noise();
    vm_item_t it;
    it.mode = 3'($urandom_range(7));
    it.opcode = 16'($urandom);
    it.addr = 12'($urandom);
    it.wdata = 8'($urandom);
    it.keys = 16'($urandom);
    it.prev = 16'($urandom);
    it.delay = 8'($urandom);
    it.rnd = 8'($urandom);
    return it;
  endfunction

  function automatic vm_item_t mk(logic [2:0] m, logic [15:0] op, logic [11:0] a = '0,
                                  logic [15:0] keys = '0, logic [15:0] prev = '0);
    vm_item_t it;
    it = rand_noise();
    it.mode = m;
    it.opcode = op;
    it.addr = a;
    it.keys = keys;
    it.prev = prev;
    return it;
  endfunction

  // Mostly meaningful instructions; a return never pops an unwritten stack slot.
  function automatic vm_item_t rand_item();
    vm_item_t it;
    logic [3:0] alu_ops [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
                                ALU_SHR, ALU_SBN, ALU_SHL};
    logic [7:0] fx_ops [9] = '{FX_GET_DELAY, FX_WAIT_KEY, FX_SET_DELAY, FX_SET_SOUND,
                               FX_ADD_I, FX_FONT, FX_BCD, FX_STORE, FX_LOAD};
    it = rand_noise();
    if ($urandom_range(99) < 30) begin
      if (it.mode == MODE_EXEC) it.mode = MODE_RD_REG;
      if (it.mode == MODE_RD_ROW || it.mode == MODE_RD_REG)
        it.addr = ($urandom_range(3) == 0) ? it.addr : 12'($urandom_range(31));
      return it;
    end
    it.mode = MODE_EXEC;
    if ($urandom_range(99) < 85) begin
      case (op_class_t'(it.opcode[15:12]))
        OP_SYS: it.opcode = $urandom_range(1) ? OPC_RET : OPC_CLS;
        OP_SE_REG, OP_SNE_REG: it.opcode[3:0] = $urandom_range(3) ? 4'h0 : it.opcode[3:0];
        OP_ALU: it.opcode[3:0] = alu_ops[$urandom_range(8)];
        OP_KEY: it.opcode[7:0] = $urandom_range(1) ? KEY_DOWN : KEY_UP;
        OP_MISC: it.opcode[7:0] = fx_ops[$urandom_range(8)];
        OP_SE_IMM, OP_SNE_IMM: if ($urandom_range(1)) it.opcode[7:0] = v_shadow[it.opcode[11:8]];
        default: ;
      endcase
      if (it.opcode[15:12] == OP_SE_REG && $urandom_range(1))
        v_shadow[0] = v_shadow[0];  // keep equal/unequal split natural
      if ($urandom_range(1)) it.prev = 16'($urandom_range(it.keys));
    end
    if (it.opcode == OPC_RET && !stack_written[sp_shadow - 4'd1])
      it.opcode = {OP_CALL, 12'($urandom)};
    return it;
  endfunction

  task automatic check_result();
    vm_result_t e;
    if (expected_q.size() == 0) begin
      $error("result with no item outstanding: pc %h", out_pc_value);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    results_seen++;
    if (out_pc_value !== e.pc) begin
      $error("pc_value exp %h got %h", e.pc, out_pc_value); errors++;
    end
    if (out_index_value !== e.index) begin
      $error("index_value exp %h got %h", e.index, out_index_value); errors++;
    end
    if (out_flag_value !== e.flag) begin
      $error("flag_value exp %h got %h", e.flag, out_flag_value); errors++;
    end
    if (out_draw_flag !== e.draw) begin
      $error("draw_flag exp %b got %b", e.draw, out_draw_flag); errors++;
    end
    if (out_timer_write !== e.twrite) begin
      $error("timer_write exp %0d got %0d", e.twrite, out_timer_write); errors++;
    end
    if (out_timer_value !== e.tval) begin
      $error("timer_value exp %h got %h", e.tval, out_timer_value); errors++;
    end
    if (out_waiting !== e.waiting) begin
      $error("waiting exp %b got %b", e.waiting, out_waiting); errors++;
    end
    if (out_read_data !== e.rdata) begin
      $error("read_data exp %h got %h", e.rdata, out_read_data); errors++;
    end
  endtask

  // Result side: random stall, check every accepted item.
  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) check_result();
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    vm_result_t reset_res;
    int phase_idle [4] = '{0, 58, 0, 35};
    int phase_stall [4] = '{0, 0, 58, 35};
    logic [11:0] fonts [4] = '{12'd0, 12'd4095, 12'd80, 12'd0};

    foreach (mem_shadow[a]) mem_shadow[a] = '0;
    foreach (v_shadow[r]) v_shadow[r] = '0;
    foreach (screen_shadow[r]) screen_shadow[r] = '0;
    foreach (stack_shadow[s]) begin stack_shadow[s] = '0; stack_written[s] = 0; end
    i_shadow = '0;
    pc_shadow = PROG_START_RST;
    sp_shadow = '0;
    font_base_q = FONT_BASE_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Right after reset: PC at program start, everything else zero.
    reset_res = '{default: '0};
    reset_res.pc = PROG_START_RST;
    dir_tab.push_back('{mk(MODE_RD_REG, '0, 12'd0), 1, reset_res});
    dir_tab.push_back('{mk(MODE_RD_REG, '0, 12'd15), 1, reset_res});
    dir_tab.push_back('{mk(MODE_RD_ROW, '0, 12'd31), 1, reset_res});
    dir_tab.push_back('{mk(MODE_RD_REG, '0, 12'd4095), 1, reset_res});
    dir_tab.push_back('{mk(3'd7, '0, 12'd0), 1, reset_res});
    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
    dir_tab.delete();

    // Fill the whole byte memory so that no later read hits an unwritten byte.
    for (int a = 0; a < MEM_DEPTH; a++) send_item(mk(MODE_WR_MEM, '0, 12'(a)));
    drain();

    // Extremes and special cases, checked against the predictor.
    dir_tab.push_back('{mk(MODE_EXEC, 16'h60FF), 0, reset_res});           // V0 = FF
    dir_tab.push_back('{mk(MODE_EXEC, 16'h61FF), 0, reset_res});
    dir_tab.push_back('{mk(MODE_EXEC, 16'h8014), 0, reset_res});           // carry out
    dir_tab.push_back('{mk(MODE_EXEC, 16'h8F15), 0, reset_res});           // VF dest, flag wins
    dir_tab.push_back('{mk(MODE_EXEC, 16'h621F), 0, reset_res});
    dir_tab.push_back('{mk(MODE_EXEC, 16'h8216), 0, reset_res});           // shift takes Vy
    dir_tab.push_back('{mk(MODE_EXEC, 16'h821E), 0, reset_res});
    dir_tab.push_back('{mk(MODE_EXEC, 16'hAFFE), 0, reset_res});           // I near top
    dir_tab.push_back('{mk(MODE_EXEC, 16'hD11F), 0, reset_res});           // clipped corner
    dir_tab.push_back('{mk(MODE_EXEC, 16'hD11F), 0, reset_res});           // collision
    dir_tab.push_back('{mk(MODE_EXEC, 16'hD330), 0, reset_res});           // zero rows
    dir_tab.push_back('{mk(MODE_RD_ROW, '0, 12'd31), 0, reset_res});
    dir_tab.push_back('{mk(MODE_EXEC, OPC_CLS), 0, reset_res});
    dir_tab.push_back('{mk(MODE_EXEC, 16'hF155), 0, reset_res});           // store reaches the last byte
    dir_tab.push_back('{mk(MODE_EXEC, 16'hFF65), 0, reset_res});
    dir_tab.push_back('{mk(MODE_EXEC, 16'hF033), 0, reset_res});
    dir_tab.push_back('{mk(MODE_EXEC, 16'hF029), 0, reset_res});
    dir_tab.push_back('{mk(MODE_EXEC, 16'hF20A, 16'h00F0, 16'h00F0), 0, reset_res}); // wait
    dir_tab.push_back('{mk(MODE_EXEC, 16'hF20A, 16'h0000, 16'hFFFF), 0, reset_res}); // release
    dir_tab.push_back('{mk(MODE_EXEC, 16'h2FFE), 0, reset_res});           // call at top
    dir_tab.push_back('{mk(MODE_EXEC, OPC_RET), 0, reset_res});
    dir_tab.push_back('{mk(MODE_EXEC, 16'hBFFF), 0, reset_res});           // PC wraps
    dir_tab.push_back('{mk(MODE_EXEC, 16'h0123), 0, reset_res});           // unknown opcode
    dir_tab.push_back('{mk(MODE_EXEC, 16'h5121), 0, reset_res});
    dir_tab.push_back('{mk(3'd5, '0, 12'd0), 0, reset_res});
    foreach (dir_tab[i]) send_item(dir_tab[i].it);

    // Random phases; each boundary drains fully before registers change.
    for (int p = 0; p < 4; p++) begin
      drain();
      write_cfg(CFG_FONT_BASE, (p == 3) ? 12'($urandom) : fonts[p]);
      write_cfg(CFG_PROG_START, (p == 0) ? 12'd0 : (p == 1) ? 12'd4095 : 12'($urandom));
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < 100; i++) send_item(rand_item());
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d items (%0d results) incl. full memory fill, all opcode groups,",
             items_sent, results_seen);
    $display("four idle/stall mixes and font_base at 0, 4095 and random values.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/c8vm_pkg.sv
hdl/c8vm_alu.sv
hdl/bytecode_vm_execute_unit_top.sv
verif/tb_bytecode_vm_execute_unit_top.sv
